### src/jwct_pkg.sv
`default_nettype none
package jwct_pkg;

	localparam int MAX_ENTRIES_DEF = 128;
	localparam int BLOCK_BITS_DEF  = 48;

	localparam int OP_W     = 2;
	localparam int STATUS_W = 3;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 32;
	localparam int THR_W    = 8;
	localparam int AGE_W    = 32;

	localparam logic [OP_W-1:0] OP_LOG    = 2'd0;
	localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
	localparam logic [OP_W-1:0] OP_TICK   = 2'd2;
	localparam logic [OP_W-1:0] OP_COMMIT = 2'd3;

	localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd0;
	localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd1;
	localparam logic [STATUS_W-1:0] ST_NO_SPACE = 3'd2;
	localparam logic [STATUS_W-1:0] ST_NO_JRNL  = 3'd3;
	localparam logic [STATUS_W-1:0] ST_DONE     = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_AGE_LIMIT = 2'd2;

	localparam logic [THR_W-1:0] THR_RESET = 8'd64;
	localparam logic [AGE_W-1:0] AGE_LIMIT_RESET = 32'd1000000;

endpackage
`default_nettype wire

### src/jwct_cell.sv
`default_nettype none
module jwct_cell #(
	parameter int IDX        = 0,
	parameter int BLOCK_BITS = 48,
	parameter int SLOT_W     = 7,
	parameter int CNT_W      = 8
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic [CNT_W-1:0]      count,
	input  wire logic                  wr_en,
	input  wire logic [SLOT_W-1:0]     wr_idx,
	input  wire logic [BLOCK_BITS-1:0] wr_key,
	input  wire logic                  tok_in_valid,
	input  wire logic [BLOCK_BITS-1:0] tok_in_key,
	input  wire logic                  tok_in_found,
	input  wire logic [SLOT_W-1:0]     tok_in_slot,
	output logic                       tok_out_valid,
	output logic [BLOCK_BITS-1:0]      tok_out_key,
	output logic                       tok_out_found,
	output logic [SLOT_W-1:0]          tok_out_slot
);

	logic [BLOCK_BITS-1:0] key_q;
	logic                  match;

	always_ff @(posedge clk) begin
		if (wr_en && wr_idx == SLOT_W'(IDX)) begin
			key_q <= wr_key;
		end
	end

	assign match = !tok_in_found && (CNT_W'(IDX) < count) && (key_q == tok_in_key);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_out_valid <= 1'b0;
		end else begin
			tok_out_valid <= tok_in_valid;
		end
	end

	always_ff @(posedge clk) begin
		tok_out_key   <= tok_in_key;
		tok_out_found <= tok_in_found || match;
		tok_out_slot  <= match ? SLOT_W'(IDX) : tok_in_slot;
	end

endmodule
`default_nettype wire

### src/journal_write_coalescing_table.sv
// Journal write-coalescing table: pending block numbers of one open transaction.
// Input channel (in_valid/in_stall) takes one word per item: operation and
// block_number. Output channel (out_valid/out_stall) returns one word per item:
// status, hit, slot, pending_count, commit_due, cleared_count.
// Configuration channel (cfg_valid/cfg_ready, always ready) writes
// index 0 journal enable, 1 commit block threshold, 2 commit age limit.
// The block works on one item at a time. Log and lookup items send a search
// word down a row of MAX_ENTRIES cells, one cell per cycle; once it leaves the
// row the item moves to the finish state, which loads the output register and
// raises out_valid, and only then is the next item taken. Tick, commit and
// items that need no search go from acceptance straight to the finish state.
// The row length sets the search latency.
// Reset empties the table, clears overflow and age, and loads the register
// defaults (journal off, threshold 64, age limit 1000000); key storage is not
// cleared since only slots below the count are read.
// A stalled result holds in the output register; the next item is still taken
// and, after its search, waits until that result is taken; later items wait
// at the input.
`default_nettype none
module journal_write_coalescing_table #(
	parameter int MAX_ENTRIES = jwct_pkg::MAX_ENTRIES_DEF,
	parameter int BLOCK_BITS  = jwct_pkg::BLOCK_BITS_DEF,
	localparam int SLOT_W = $clog2(MAX_ENTRIES),
	localparam int CNT_W  = $clog2(MAX_ENTRIES + 1)
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [jwct_pkg::OP_W-1:0]       operation,
	input  wire logic [BLOCK_BITS-1:0]           block_number,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [jwct_pkg::STATUS_W-1:0]        status,
	output logic                                 hit,
	output logic [SLOT_W-1:0]                    slot,
	output logic [CNT_W-1:0]                     pending_count,
	output logic                                 commit_due,
	output logic [CNT_W-1:0]                     cleared_count,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [jwct_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [jwct_pkg::CFG_DATA_W-1:0] cfg_data
);

	import jwct_pkg::*;

	localparam int CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;

	localparam logic [1:0] S_IDLE   = 2'd0;
	localparam logic [1:0] S_SEARCH = 2'd1;
	localparam logic [1:0] S_FINISH = 2'd2;

	logic [1:0] state_q;

	logic             en_q;
	logic [THR_W-1:0] thr_q;
	logic [AGE_W-1:0] lim_q;

	logic [CNT_W-1:0] cnt_q;
	logic             ovf_q;
	logic [AGE_W-1:0] age_q;

	logic [OP_W-1:0]       op_q;
	logic [BLOCK_BITS-1:0] key_q;
	logic                  found_q;
	logic [SLOT_W-1:0]     fslot_q;

	logic                  tv [0:MAX_ENTRIES];
	logic [BLOCK_BITS-1:0] tk [0:MAX_ENTRIES];
	logic                  tf [0:MAX_ENTRIES];
	logic [SLOT_W-1:0]     ts [0:MAX_ENTRIES];

	logic accept;
	logic need_search;
	logic fin_go;

	logic [CNT_W-1:0]    cnt_n;
	logic                ovf_n;
	logic [AGE_W-1:0]    age_n;
	logic [STATUS_W-1:0] status_n;
	logic                hit_n;
	logic [SLOT_W-1:0]   slot_n;
	logic [CNT_W-1:0]    cleared_n;
	logic                due_n;
	logic                wr_en;

	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign accept    = in_valid && !in_stall;
	assign need_search = en_q && ((operation == OP_LOOKUP) ||
		((operation == OP_LOG) && !ovf_q));
	assign fin_go = (state_q == S_FINISH) && (!out_valid || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_q  <= 1'b0;
			thr_q <= THR_RESET;
			lim_q <= AGE_LIMIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_ENABLE:    en_q  <= cfg_data[0];
				CFG_THRESHOLD: thr_q <= cfg_data[THR_W-1:0];
				CFG_AGE_LIMIT: lim_q <= cfg_data[AGE_W-1:0];
				default: ;
			endcase
		end
	end

	// search word entering the row
	assign tv[0] = accept && need_search;
	assign tk[0] = block_number;
	assign tf[0] = 1'b0;
	assign ts[0] = '0;

	for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
		jwct_cell #(
			.IDX        (i),
			.BLOCK_BITS (BLOCK_BITS),
			.SLOT_W     (SLOT_W),
			.CNT_W      (CNT_W)
		) u_cell (
			.clk           (clk),
			.arst_n        (arst_n),
			.count         (cnt_q),
			.wr_en         (wr_en),
			.wr_idx        (cnt_q[SLOT_W-1:0]),
			.wr_key        (key_q),
			.tok_in_valid  (tv[i]),
			.tok_in_key    (tk[i]),
			.tok_in_found  (tf[i]),
			.tok_in_slot   (ts[i]),
			.tok_out_valid (tv[i+1]),
			.tok_out_key   (tk[i+1]),
			.tok_out_found (tf[i+1]),
			.tok_out_slot  (ts[i+1])
		);
	end

	always_comb begin
		cnt_n     = cnt_q;
		ovf_n     = ovf_q;
		age_n     = age_q;
		status_n  = ST_DONE;
		hit_n     = 1'b0;
		slot_n    = '0;
		cleared_n = '0;
		wr_en     = 1'b0;
		case (op_q)
			OP_LOG: begin
				if (!en_q) begin
					status_n = ST_NO_JRNL;
				end else if (ovf_q) begin
					status_n = ST_NO_SPACE;
				end else begin
					if (cnt_q == '0) begin
						age_n = '0;
					end
					if (found_q) begin
						status_n = ST_UPDATED;
						hit_n    = 1'b1;
						slot_n   = fslot_q;
					end else if (cnt_q >= CNT_W'(MAX_ENTRIES)) begin
						ovf_n    = 1'b1;
						status_n = ST_NO_SPACE;
					end else begin
						wr_en    = fin_go;
						slot_n   = cnt_q[SLOT_W-1:0];
						cnt_n    = cnt_q + CNT_W'(1);
						status_n = ST_INSERTED;
					end
				end
			end
			OP_LOOKUP: begin
				hit_n  = found_q;
				slot_n = fslot_q;
			end
			OP_TICK: begin
				if (age_q != '1) begin
					age_n = age_q + AGE_W'(1);
				end
			end
			default: begin
				cleared_n = cnt_q;
				cnt_n     = '0;
				ovf_n     = 1'b0;
				age_n     = '0;
			end
		endcase
		due_n = en_q && ((cnt_n != '0) || ovf_n) &&
			(ovf_n || (CMP_W'(cnt_n) >= CMP_W'(thr_q)) || (age_n >= lim_q));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			ovf_q   <= 1'b0;
			age_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (fin_go) begin
				out_valid <= 1'b1;
			end else if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= need_search ? S_SEARCH : S_FINISH;
					end
				end
				S_SEARCH: begin
					if (tv[MAX_ENTRIES]) begin
						state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (fin_go) begin
						state_q   <= S_IDLE;
						cnt_q     <= cnt_n;
						ovf_q     <= ovf_n;
						age_q     <= age_n;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= operation;
			key_q   <= block_number;
			found_q <= 1'b0;
			fslot_q <= '0;
		end else if (tv[MAX_ENTRIES]) begin
			found_q <= tf[MAX_ENTRIES];
			fslot_q <= ts[MAX_ENTRIES];
		end
		if (fin_go) begin
			status        <= status_n;
			hit           <= hit_n;
			slot          <= slot_n;
			pending_count <= cnt_n;
			commit_due    <= due_n;
			cleared_count <= cleared_n;
		end
	end

`ifndef SYNTHESIS
	a_tok_in_search: assert property (@(posedge clk) disable iff (!arst_n)
		tv[MAX_ENTRIES] |-> state_q == S_SEARCH)
		else $error("search word left the row outside a search");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_ENTRIES))
		else $error("entry count above table size");
	a_ovf_full: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> cnt_q == CNT_W'(MAX_ENTRIES))
		else $error("overflow set with free slots");
	a_fin_loads: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go |=> out_valid && state_q == S_IDLE)
		else $error("finished item did not reach the output register");
`endif

endmodule
`default_nettype wire
